### sv/pps_pkg.sv
// Package for the pure pursuit steering block: sequencer states, phases,
// fixed-point constants and the arctangent table of the CORDIC unit.
// No dependencies.
package pps_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] REG_WHEELBASE = 2'd1;
  localparam logic [1:0] REG_STEER_LIM = 2'd2;

  localparam logic [20:0] LOOKAHEAD_RST = 21'd52429;
  localparam logic [19:0] WHEELBASE_RST = 20'd19661;
  localparam logic [13:0] STEER_LIM_RST = 14'd2787;

  // Angles in Q.24
  localparam logic signed [28:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [28:0] HALF_PI_Q24 = 29'sd26353589;
  localparam logic [32:0]        GAIN_Q24    = 33'd10188014;

  localparam int CORDIC_ITERS = 24;
  localparam int SQRT_STEPS   = 33;
  localparam int DIV_STEPS    = 72;

  typedef enum logic [5:0] {
    ST_IDLE, ST_PL_RD0, ST_PL_LD0, ST_PT_RD, ST_PT_LD, ST_SQX, ST_SQY, ST_SQADD,
    ST_SQRT_LD, ST_SQRT, ST_SEG_DONE, ST_NR_INIT, ST_NR_CMP, ST_WK_INIT, ST_WK_LDT,
    ST_WK_RDP, ST_WK_LDP, ST_DIV, ST_DIV_DONE, ST_WK_MX, ST_WK_AX, ST_WK_MY,
    ST_WK_AY, ST_ROT_INIT, ST_ROT, ST_ROT_GX, ST_ROT_RX, ST_ROT_GY, ST_ROT_RY,
    ST_CV_LL, ST_CV_NUM, ST_CV_DL, ST_CV_T, ST_ATAN, ST_ATAN_DONE, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_LEN, PH_NEAR, PH_WALK, PH_CURV
  } phase_e;

  // atan(2^-i) in Q.24
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] r;
    case (i)
      5'd0:    r = 24'd13176795;
      5'd1:    r = 24'd7778716;
      5'd2:    r = 24'd4110060;
      5'd3:    r = 24'd2086331;
      5'd4:    r = 24'd1047214;
      5'd5:    r = 24'd524117;
      5'd6:    r = 24'd262123;
      5'd7:    r = 24'd131069;
      5'd8:    r = 24'd65536;
      5'd9:    r = 24'd32768;
      5'd10:   r = 24'd16384;
      5'd11:   r = 24'd8192;
      5'd12:   r = 24'd4096;
      5'd13:   r = 24'd2048;
      5'd14:   r = 24'd1024;
      5'd15:   r = 24'd512;
      5'd16:   r = 24'd256;
      5'd17:   r = 24'd128;
      5'd18:   r = 24'd64;
      5'd19:   r = 24'd32;
      5'd20:   r = 24'd16;
      5'd21:   r = 24'd8;
      5'd22:   r = 24'd4;
      5'd23:   r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/pure_pursuit_steering.sv
// Pure pursuit steering: path store, sequencer, shared multiplier,
// shared sqrt/divide step and shared CORDIC step. Uses pps_pkg.
//
// Loading takes one item per cycle; the block is not ready while it computes.
// After the item marked last, a path of at least two points yields a result;
// the run is set by the 33-step square root per segment, the 72-step divider
// and up to two 24-step CORDIC passes. Reset clears the point count and the
// registers to defaults; the path store is not cleared.
module pure_pursuit_steering
  import pps_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [20:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x[31:0], point_y[63:32], veh_x[95:64], veh_y[127:96], veh_yaw[143:128]
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // steer_angle[14:0], target_x[46:15], target_y[78:47], path_length[110:79]
  output logic [111:0] m_axis_tdata,
  // used_end_point[0]
  output logic         m_axis_tuser
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = 34 + CW;

  logic [63:0] mem_q [MAX_POINTS];
  logic [63:0] rd_q;
  logic [IW-1:0] rd_addr;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, idx_q, idx_d, near_q, near_d;
  logic [20:0] lad_q, lad_d;
  logic [19:0] wb_q, wb_d;
  logic [13:0] lim_q, lim_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [15:0] yaw_q, yaw_d;
  logic signed [31:0] prv_x_q, prv_x_d, prv_y_q, prv_y_d;
  logic signed [31:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [68:0] prod_q, prod_d;
  logic [65:0] sum_q, sum_d, best_q, best_d;
  logic [71:0] src_q, src_d, quo_q, quo_d;
  logic [44:0] rem_q, rem_d;
  logic [42:0] dv_q, dv_d;
  logic [6:0]  step_q, step_d;
  logic [31:0] plen_q, plen_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [24:0] ratio_q, ratio_d;
  logic signed [31:0] tx_q, tx_d, ty_q, ty_d;
  logic endu_q, endu_d;
  logic signed [41:0] crx_q, crx_d, cry_q, cry_d;
  logic signed [28:0] crz_q, crz_d;
  logic signed [35:0] lx_q, lx_d, ly_q, ly_d;
  logic signed [15:0] ang_q, ang_d;
  logic [111:0] o_data_q, o_data_d;
  logic o_user_q, o_user_d, o_valid_q, o_valid_d;

  // Intermediate values
  logic in_acc, wr_en;
  logic [CW-1:0] cnt_inc;
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [35:0] mul_a;
  logic [32:0] mul_b;
  logic [68:0] prod;
  logic [20:0] l_eff;
  logic [44:0] rs_sh, rs_trial, rs_diff;
  logic rs_ge, rs_sqrt;
  logic signed [41:0] xs, ys;
  logic signed [28:0] tab;
  logic cr_pos, cr_vec;
  logic [33:0] psum;
  logic [AW-1:0] acc_n;
  logic [20:0] rem_l;
  logic [56:0] rnd57;
  logic [33:0] irnd;
  logic signed [33:0] tsum;
  logic [58:0] rnd59;
  logic [34:0] gmag;
  logic signed [32:0] ex, ey;
  logic signed [28:0] ang0;
  logic signed [41:0] rx0, ry0;
  logic [35:0] aly, acrx, acry;
  logic [31:0] t32;
  logic [28:0] zr;
  logic [14:0] amag;
  logic signed [15:0] lim16, ac, an;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign wr_en = in_acc && (cnt_q < CW'(MAX_POINTS));
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata = o_data_q;
  assign m_axis_tuser = o_user_q;

  // Path store: one write port for loading, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IW-1:0]] <= {s_axis_tdata[63:32], s_axis_tdata[31:0]};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    rd_addr = idx_q[IW-1:0];
    unique case (state_q)
      ST_PL_RD0: rd_addr = '0;
      ST_WK_INIT: rd_addr = IW'(n_q - CW'(1));
      ST_WK_RDP: rd_addr = near_q[IW-1:0];
      default: rd_addr = idx_q[IW-1:0];
    endcase
  end

  // Segment or distance offsets and their magnitudes
  assign dx = 33'(cur_x_q) - 33'(prv_x_q);
  assign dy = 33'(cur_y_q) - 33'(prv_y_q);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign l_eff = (lad_q == '0) ? 21'd1 : lad_q;
  assign aly = ly_q[35] ? 36'(-ly_q) : 36'(ly_q);
  assign acrx = crx_q[41] ? 36'(-crx_q) : crx_q[35:0];
  assign acry = cry_q[41] ? 36'(-cry_q) : cry_q[35:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQX: begin mul_a = 36'(adx); mul_b = adx; end
      ST_SQY: begin mul_a = 36'(ady); mul_b = ady; end
      ST_WK_MX: begin mul_a = 36'(adx); mul_b = 33'(ratio_q); end
      ST_WK_MY: begin mul_a = 36'(ady); mul_b = 33'(ratio_q); end
      ST_ROT_GX: begin mul_a = acrx; mul_b = GAIN_Q24; end
      ST_ROT_GY: begin mul_a = acry; mul_b = GAIN_Q24; end
      ST_CV_LL: begin mul_a = 36'(l_eff); mul_b = 33'(l_eff); end
      ST_CV_NUM: begin mul_a = aly; mul_b = 33'(wb_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = 69'(mul_a) * 69'(mul_b);

  // Shared restoring step for square root and division
  assign rs_sqrt = (state_q == ST_SQRT);
  assign rs_sh = rs_sqrt ? {rem_q[42:0], src_q[71:70]} : {rem_q[43:0], src_q[71]};
  assign rs_trial = rs_sqrt ? {quo_q[42:0], 2'b01} : {2'b00, dv_q};
  assign rs_ge = (rs_sh >= rs_trial);
  assign rs_diff = rs_sh - rs_trial;

  // Shared CORDIC step, rotation or vectoring
  assign cr_vec = (state_q == ST_ATAN);
  assign xs = crx_q >>> step_q[4:0];
  assign ys = cry_q >>> step_q[4:0];
  assign tab = 29'(atan_q24(step_q[4:0]));
  assign cr_pos = cr_vec ? (cry_q <= 42'sd0) : (crz_q >= 29'sd0);

  assign cnt_inc = cnt_q + CW'(wr_en);
  assign psum = 34'(plen_q) + 34'(quo_q[32:0]);
  assign acc_n = acc_q + AW'(quo_q[32:0]);
  assign rem_l = l_eff - acc_q[20:0];
  assign rnd57 = prod_q[56:0] + 57'(1 << 23);
  assign irnd = 34'(rnd57[56:24]);
  assign rnd59 = prod_q[58:0] + 59'(1 << 23);
  assign gmag = rnd59[58:24];
  assign ex = 33'(tx_q) - 33'(vx_q);
  assign ey = 33'(ty_q) - 33'(vy_q);
  assign ang0 = -(29'(yaw_q) <<< 11);
  assign t32 = (|quo_q[71:31]) ? 32'h8000_0000 : quo_q[31:0];
  assign zr = (crz_q[28] ? 29'd0 : 29'(crz_q)) + 29'd1024;
  assign amag = zr[25:11];
  assign lim16 = 16'(lim_q);

  always_comb begin
    tsum = '0;
    rx0 = 42'(ex);
    ry0 = 42'(ey);
    ac = ang_q;
    an = '0;
    state_d = state_q;
    ph_d = ph_q;
    cnt_d = cnt_q;
    n_d = n_q;
    idx_d = idx_q;
    near_d = near_q;
    lad_d = lad_q;
    wb_d = wb_q;
    lim_d = lim_q;
    vx_d = vx_q;
    vy_d = vy_q;
    yaw_d = yaw_q;
    prv_x_d = prv_x_q;
    prv_y_d = prv_y_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    prod_d = prod_q;
    sum_d = sum_q;
    best_d = best_q;
    src_d = src_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dv_d = dv_q;
    step_d = step_q;
    plen_d = plen_q;
    acc_d = acc_q;
    ratio_d = ratio_q;
    tx_d = tx_q;
    ty_d = ty_q;
    endu_d = endu_q;
    crx_d = crx_q;
    cry_d = cry_q;
    crz_d = crz_q;
    lx_d = lx_q;
    ly_d = ly_q;
    ang_d = ang_q;
    o_data_d = o_data_q;
    o_user_d = o_user_q;
    o_valid_d = o_valid_q && !m_axis_tready;

    // Write configuration registers
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOOKAHEAD: lad_d = cfg_wdata_i;
        REG_WHEELBASE: wb_d = cfg_wdata_i[19:0];
        REG_STEER_LIM: lim_d = cfg_wdata_i[13:0];
        default: ;
      endcase
    end

    unique case (state_q)
      // Load points; the last item carries the pose and, with two points or more, starts the run
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d = cnt_inc;
          if (s_axis_tlast) begin
            cnt_d = '0;
            n_d = cnt_inc;
            vx_d = s_axis_tdata[95:64];
            vy_d = s_axis_tdata[127:96];
            yaw_d = s_axis_tdata[143:128];
            plen_d = '0;
            ph_d = PH_LEN;
            if (cnt_inc >= CW'(2)) state_d = ST_PL_RD0;
          end
        end
      end
      ST_PL_RD0: state_d = ST_PL_LD0;
      ST_PL_LD0: begin
        prv_x_d = rd_q[31:0];
        prv_y_d = rd_q[63:32];
        idx_d = CW'(1);
        state_d = ST_PT_RD;
      end
      ST_PT_RD: state_d = ST_PT_LD;
      ST_PT_LD: begin
        cur_x_d = rd_q[31:0];
        cur_y_d = rd_q[63:32];
        state_d = ST_SQX;
      end
      // Squared distance through the shared multiplier
      ST_SQX: begin
        prod_d = prod;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        sum_d = prod_q[65:0];
        prod_d = prod;
        state_d = ST_SQADD;
      end
      ST_SQADD: begin
        sum_d = sum_q + prod_q[65:0];
        state_d = (ph_q == PH_NEAR) ? ST_NR_CMP : ST_SQRT_LD;
      end
      ST_SQRT_LD: begin
        src_d = {sum_q, 6'b0};
        rem_d = '0;
        quo_d = '0;
        step_d = '0;
        state_d = ST_SQRT;
      end
      // One root bit per cycle
      ST_SQRT: begin
        src_d = {src_q[69:0], 2'b00};
        rem_d = rs_ge ? rs_diff : rs_sh;
        quo_d = {quo_q[70:0], rs_ge};
        step_d = step_q + 7'd1;
        if (step_q == 7'(SQRT_STEPS - 1)) state_d = ST_SEG_DONE;
      end
      ST_SEG_DONE: begin
        if (ph_q == PH_LEN) begin
          // Saturating path length
          plen_d = (|psum[33:32]) ? 32'hFFFF_FFFF : psum[31:0];
          prv_x_d = cur_x_q;
          prv_y_d = cur_y_q;
          if (idx_q + CW'(1) < n_q) begin
            idx_d = idx_q + CW'(1);
            state_d = ST_PT_RD;
          end else begin
            state_d = ST_NR_INIT;
          end
        end else if (acc_n >= AW'(l_eff)) begin
          // Lookahead falls on this segment: ratio = rem*2^24/seg
          dv_d = 43'(quo_q[32:0]);
          src_d = {27'b0, rem_l, 24'b0};
          rem_d = '0;
          quo_d = '0;
          step_d = '0;
          state_d = ST_DIV;
        end else begin
          acc_d = acc_n;
          prv_x_d = cur_x_q;
          prv_y_d = cur_y_q;
          if (idx_q + CW'(1) < n_q) begin
            idx_d = idx_q + CW'(1);
            state_d = ST_PT_RD;
          end else begin
            state_d = ST_ROT_INIT;
          end
        end
      end
      ST_NR_INIT: begin
        prv_x_d = vx_q;
        prv_y_d = vy_q;
        idx_d = '0;
        ph_d = PH_NEAR;
        state_d = ST_PT_RD;
      end
      // Keep the nearest point, lower index on a tie
      ST_NR_CMP: begin
        if (idx_q == '0 || sum_q < best_q) begin
          best_d = sum_q;
          near_d = idx_q;
        end
        if (idx_q + CW'(1) < n_q) begin
          idx_d = idx_q + CW'(1);
          state_d = ST_PT_RD;
        end else begin
          state_d = ST_WK_INIT;
        end
      end
      ST_WK_INIT: begin
        ph_d = PH_WALK;
        state_d = ST_WK_LDT;
      end
      ST_WK_LDT: begin
        tx_d = rd_q[31:0];
        ty_d = rd_q[63:32];
        acc_d = '0;
        endu_d = 1'b1;
        idx_d = near_q + CW'(1);
        state_d = (near_q + CW'(1) >= n_q) ? ST_ROT_INIT : ST_WK_RDP;
      end
      ST_WK_RDP: state_d = ST_WK_LDP;
      ST_WK_LDP: begin
        prv_x_d = rd_q[31:0];
        prv_y_d = rd_q[63:32];
        state_d = ST_PT_RD;
      end
      // One quotient bit per cycle
      ST_DIV: begin
        src_d = {src_q[70:0], 1'b0};
        rem_d = rs_ge ? rs_diff : rs_sh;
        quo_d = {quo_q[70:0], rs_ge};
        step_d = step_q + 7'd1;
        if (step_q == 7'(DIV_STEPS - 1)) state_d = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        if (ph_q == PH_WALK) begin
          ratio_d = (dv_q == '0) ? 25'd0 : quo_q[24:0];
          state_d = ST_WK_MX;
        end else begin
          state_d = ST_CV_T;
        end
      end
      // Interpolate the target, rounding half away from zero
      ST_WK_MX: begin
        prod_d = prod;
        state_d = ST_WK_AX;
      end
      ST_WK_AX: begin
        tsum = 34'(prv_x_q) + (dx[32] ? 34'(-irnd) : irnd);
        tx_d = tsum[31:0];
        state_d = ST_WK_MY;
      end
      ST_WK_MY: begin
        prod_d = prod;
        state_d = ST_WK_AY;
      end
      ST_WK_AY: begin
        tsum = 34'(prv_y_q) + (dy[32] ? 34'(-irnd) : irnd);
        ty_d = tsum[31:0];
        endu_d = 1'b0;
        state_d = ST_ROT_INIT;
      end
      // Set up rotation by -yaw, folding angles beyond a quarter turn
      ST_ROT_INIT: begin
        crz_d = ang0;
        crx_d = rx0;
        cry_d = ry0;
        if (ang0 > HALF_PI_Q24) begin
          crz_d = ang0 - PI_Q24;
          crx_d = -rx0;
          cry_d = -ry0;
        end else if (ang0 < -HALF_PI_Q24) begin
          crz_d = ang0 + PI_Q24;
          crx_d = -rx0;
          cry_d = -ry0;
        end
        step_d = '0;
        state_d = ST_ROT;
      end
      ST_ROT, ST_ATAN: begin
        if (cr_pos) begin
          crx_d = crx_q - ys;
          cry_d = cry_q + xs;
          crz_d = crz_q - tab;
        end else begin
          crx_d = crx_q + ys;
          cry_d = cry_q - xs;
          crz_d = crz_q + tab;
        end
        step_d = step_q + 7'd1;
        if (step_q == 7'(CORDIC_ITERS - 1)) begin
          state_d = cr_vec ? ST_ATAN_DONE : ST_ROT_GX;
        end
      end
      // Remove CORDIC gain
      ST_ROT_GX: begin
        prod_d = prod;
        state_d = ST_ROT_RX;
      end
      ST_ROT_RX: begin
        lx_d = crx_q[41] ? -36'(gmag) : 36'(gmag);
        state_d = ST_ROT_GY;
      end
      ST_ROT_GY: begin
        prod_d = prod;
        state_d = ST_ROT_RY;
      end
      ST_ROT_RY: begin
        ly_d = cry_q[41] ? -36'(gmag) : 36'(gmag);
        ang_d = '0;
        state_d = (lx_q == '0) ? ST_FIN : ST_CV_LL;
      end
      // Curvature term 2*|y|*wheelbase/L^2 in Q.16
      ST_CV_LL: begin
        prod_d = prod;
        ph_d = PH_CURV;
        state_d = ST_CV_NUM;
      end
      ST_CV_NUM: begin
        dv_d = prod_q[42:0];
        prod_d = prod;
        state_d = ST_CV_DL;
      end
      ST_CV_DL: begin
        src_d = {prod_q[54:0], 17'b0};
        rem_d = '0;
        quo_d = '0;
        step_d = '0;
        state_d = ST_DIV;
      end
      ST_CV_T: begin
        crx_d = 42'sd16777216;
        cry_d = 42'({2'b00, t32, 8'b0});
        crz_d = '0;
        step_d = '0;
        state_d = ST_ATAN;
      end
      ST_ATAN_DONE: begin
        ang_d = ly_q[35] ? -16'(amag) : 16'(amag);
        state_d = ST_FIN;
      end
      // Clamp, negate and hold the result for the output side
      ST_FIN: begin
        if (!o_valid_q || m_axis_tready) begin
          if (ac > lim16) ac = lim16;
          if (ac < -lim16) ac = -lim16;
          an = -ac;
          o_data_d = {1'b0, plen_q, ty_q, tx_q, an[14:0]};
          o_user_d = endu_q;
          o_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q <= PH_LEN;
      cnt_q <= '0;
      step_q <= '0;
      lad_q <= LOOKAHEAD_RST;
      wb_q <= WHEELBASE_RST;
      lim_q <= STEER_LIM_RST;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      cnt_q <= cnt_d;
      step_q <= step_d;
      lad_q <= lad_d;
      wb_q <= wb_d;
      lim_q <= lim_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    idx_q <= idx_d;
    near_q <= near_d;
    vx_q <= vx_d;
    vy_q <= vy_d;
    yaw_q <= yaw_d;
    prv_x_q <= prv_x_d;
    prv_y_q <= prv_y_d;
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    prod_q <= prod_d;
    sum_q <= sum_d;
    best_q <= best_d;
    src_q <= src_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dv_q <= dv_d;
    plen_q <= plen_d;
    acc_q <= acc_d;
    ratio_q <= ratio_d;
    tx_q <= tx_d;
    ty_q <= ty_d;
    endu_q <= endu_d;
    crx_q <= crx_d;
    cry_q <= cry_d;
    crz_q <= crz_d;
    lx_q <= lx_d;
    ly_q <= ly_d;
    ang_q <= ang_d;
    o_data_q <= o_data_d;
    o_user_q <= o_user_d;
  end

endmodule

### dv/pure_pursuit_steering_test.sv
// Self-checking bench for the pure pursuit steering block: loads random and
// directed paths, predicts target, steering and path length, checks each result.
// Depends on pps_pkg and pure_pursuit_steering.
module pure_pursuit_steering_test
  import pps_pkg::*;
();

  localparam int MAXP = 256;
  localparam int WD_LIMIT = 400000;

  typedef struct {
    logic signed [14:0] steer;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic               end_used;
    logic [31:0]        plen;
  } steer_res_t;

  // Predictor of the steering result plus the queue of pending results
  class steer_scoreboard;
    longint px[MAXP];
    longint py[MAXP];
    int unsigned count;
    longint look, wheel, lim;
    steer_res_t pending[$];
    int errors;

    function void reset_state();
      count = 0; look = 52429; wheel = 19661; lim = 2787;
      pending.delete(); errors = 0;
    endfunction

    function longint ashr(longint v, int s);
      return v >>> s;
    endfunction

    function longint rnd_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return v < 0 ? -m : m;
    endfunction

    function logic [65:0] dist_sq(longint dx, longint dy);
      logic [65:0] ax, ay;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      return ax * ax + ay * ay;
    endfunction

    function longint seg_length(longint dx, longint dy);
      logic [65:0] v;
      logic [67:0] rem, trial;
      logic [35:0] root;
      v = dist_sq(dx, dy);
      rem = 0; root = 0;
      for (int k = 32; k >= 0; k--) begin
        rem = (rem << 2) | v[2*k +: 2];
        trial = {root, 2'b01};
        if (rem >= trial) begin
          rem -= trial; root = {root[34:0], 1'b1};
        end else begin
          root = {root[34:0], 1'b0};
        end
      end
      return longint'(root);
    endfunction

    function longint atan_step(int i);
      return longint'(atan_q24(i[4:0]));
    endfunction

    function void note_config(logic [1:0] idx, logic [20:0] val);
      case (idx)
        REG_LOOKAHEAD: look = val;
        REG_WHEELBASE: wheel = val[19:0];
        REG_STEER_LIM: lim = val[13:0];
        default: ;
      endcase
    endfunction

    // Store a point; on the last one predict the result if the path has two points or more
    function void note_item(logic [143:0] d, logic last);
      int unsigned n, near;
      longint vx, vy, yaw, tx, ty, x, y, a, nx, lx, ly, ang, el, acc, sg, plen;
      logic [65:0] best, cur;
      logic [127:0] num, den, q, t;
      logic eu;
      steer_res_t r;
      if (count < MAXP) begin
        px[count] = longint'($signed(d[31:0]));
        py[count] = longint'($signed(d[63:32]));
        count++;
      end
      if (!last) return;
      n = count; count = 0;
      if (n < 2) return;
      vx = longint'($signed(d[95:64]));
      vy = longint'($signed(d[127:96]));
      yaw = longint'($signed(d[143:128]));
      el = look != 0 ? look : 1;
      plen = 0;
      for (int i = 1; i < n; i++) begin
        plen += seg_length(px[i] - px[i-1], py[i] - py[i-1]);
        if (plen > 64'hFFFFFFFF) plen = 64'hFFFFFFFF;
      end
      near = 0;
      best = dist_sq(px[0] - vx, py[0] - vy);
      for (int i = 1; i < n; i++) begin
        cur = dist_sq(px[i] - vx, py[i] - vy);
        if (cur < best) begin best = cur; near = i; end
      end
      tx = px[n-1]; ty = py[n-1]; eu = 1; acc = 0;
      for (int i = near + 1; i < n; i++) begin
        longint dx, dy, rem, ratio;
        dx = px[i] - px[i-1]; dy = py[i] - py[i-1];
        sg = seg_length(dx, dy);
        acc += sg;
        if (acc >= el) begin
          rem = el - (acc - sg);
          ratio = sg != 0 ? (rem <<< 24) / sg : 0;
          tx = px[i-1] + rnd_shift(dx * ratio, 24);
          ty = py[i-1] + rnd_shift(dy * ratio, 24);
          eu = 0;
          break;
        end
      end
      // Rotate the target offset into the vehicle frame
      x = tx - vx; y = ty - vy; a = -(yaw * 2048);
      if (a > HALF_PI_Q24) begin a -= PI_Q24; x = -x; y = -y; end
      else if (a < -HALF_PI_Q24) begin a += PI_Q24; x = -x; y = -y; end
      for (int i = 0; i < 24; i++) begin
        if (a >= 0) begin
          nx = x - ashr(y, i); y = y + ashr(x, i); a -= atan_step(i);
        end else begin
          nx = x + ashr(y, i); y = y - ashr(x, i); a += atan_step(i);
        end
        x = nx;
      end
      lx = rnd_shift(x * longint'(GAIN_Q24), 24);
      ly = rnd_shift(y * longint'(GAIN_Q24), 24);
      ang = 0;
      if (lx != 0) begin
        longint cx, cy, z;
        num = 2 * (ly < 0 ? -ly : ly) * wheel;
        den = el * el;
        q = num / den;
        if (q >= 32768) t = 128'd32768 << 16;
        else t = (q << 16) + (((num % den) << 16) / den);
        cx = 64'sd1 <<< 24; cy = longint'(t) * 256; z = 0;
        for (int i = 0; i < 24; i++) begin
          if (cy > 0) begin
            nx = cx + ashr(cy, i); cy = cy - ashr(cx, i); z += atan_step(i);
          end else begin
            nx = cx - ashr(cy, i); cy = cy + ashr(cx, i); z -= atan_step(i);
          end
          cx = nx;
        end
        if (z < 0) z = 0;
        ang = (z + 1024) >>> 11;
        if (ly < 0) ang = -ang;
      end
      if (ang > lim) ang = lim;
      if (ang < -lim) ang = -lim;
      r.steer = -ang; r.tx = tx; r.ty = ty; r.end_used = eu; r.plen = plen;
      pending.push_back(r);
    endfunction

    function void check_result(logic [111:0] d, logic u);
      steer_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d); errors++; return;
      end
      e = pending.pop_front();
      if (d[14:0] !== e.steer) begin
        $error("steer_angle exp %0d got %0d", e.steer, $signed(d[14:0])); errors++;
      end
      if (d[46:15] !== e.tx) begin
        $error("target_x exp %0d got %0d", e.tx, $signed(d[46:15])); errors++;
      end
      if (d[78:47] !== e.ty) begin
        $error("target_y exp %0d got %0d", e.ty, $signed(d[78:47])); errors++;
      end
      if (u !== e.end_used) begin
        $error("used_end_point exp %0d got %0d", e.end_used, u); errors++;
      end
      if (d[110:79] !== e.plen) begin
        $error("path_length exp %0d got %0d", e.plen, d[110:79]); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = REG_LOOKAHEAD;
  logic [20:0] cfg_wdata_i = 0;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tlast = 0;
  logic [143:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [111:0] m_axis_tdata;
  steer_scoreboard sb;
  int idle_cycles = 0;
  bit done = 0;

  pure_pursuit_steering dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Check results and watch for a stalled run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("** pure_pursuit_steering: FAILED **");
        $finish;
      end
    end
  end

  // Receiver with random stalls and stall-free stretches
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        m_axis_tready <= 0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.note_config(idx, val);
  endtask

  task automatic send_item(logic [143:0] d, logic last, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (w > 0) begin
      s_axis_tvalid <= 0;
      repeat (w - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= d; s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(d, last);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic logic [15:0] rand_yaw();
    case ($urandom_range(0, 5))
      0: return 16'sd25736;
      1: return -16'sd25736;
      default: return 16'($signed($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  function automatic logic [31:0] px_near(logic [31:0] v);
    return v + 32'($signed($urandom_range(0, 100000)) - 50000);
  endfunction
  function automatic logic [31:0] py_near(logic [31:0] v);
    return v + 32'($signed($urandom_range(0, 100000)) - 50000);
  endfunction

  // Send a path of n points with the pose on the last one
  task automatic send_path(int n, int mode, bit gaps);
    logic [143:0] d;
    logic [31:0] x, y;
    x = rand_coord(mode); y = rand_coord(mode);
    for (int i = 0; i < n; i++) begin
      if (mode == 2 && i > 0) begin
        x += 32'($signed($urandom_range(0, 60000)) - 10000);
        y += 32'($signed($urandom_range(0, 40000)) - 20000);
      end else if (i > 0) begin
        x = rand_coord(mode); y = rand_coord(mode);
      end
      d = {rand_yaw(), rand_coord(mode), rand_coord(mode), y, x};
      if (mode == 2) d[127:64] = {py_near(y), px_near(x)};
      send_item(d, i == n - 1, gaps);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    logic [143:0] d;
    int items;
    sb = new();
    sb.reset_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: extremes, short paths, store overflow
    d = {16'sd25736, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
    send_item(d, 1, 0);
    send_item({16'd0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'h80000000}, 0, 0);
    send_item({-16'sd25736, 32'd0, 32'd0, 32'h80000000, 32'h7FFFFFFF}, 1, 0);
    send_item({16'd0, 32'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 0, 0);
    send_item({16'd0, 32'd0, 32'd0, 32'h0, 32'h0}, 1, 0);
    send_item({16'd0, 32'd0, 32'd65536, 32'd0, 32'd0}, 0, 0);
    send_item({16'd0, 32'd0, 32'd65536, 32'd0, 32'd0}, 1, 0);
    send_item({16'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 0, 0);
    send_item({16'd0, 32'd0, 32'd0, 32'd65536, 32'd0}, 1, 0);
    for (int i = 0; i < MAXP + 3; i++)
      send_item({16'd1000, 32'd0, 32'd0, 32'(i * 30000), 32'(i * 20000)},
                i == MAXP + 2, 1);
    drain();

    // Extreme register settings
    write_reg(REG_LOOKAHEAD, 21'd0);
    write_reg(REG_WHEELBASE, 21'd655360);
    write_reg(REG_STEER_LIM, 21'd16383);
    send_path(5, 2, 0);
    send_path(3, 0, 1);
    drain();
    write_reg(REG_LOOKAHEAD, 21'h1FFFFF);
    write_reg(REG_WHEELBASE, 21'hFFFFF);
    write_reg(REG_STEER_LIM, 21'd0);
    send_path(6, 2, 1);
    send_path(4, 1, 0);
    drain();

    // Random paths over several register settings
    items = 0;
    while (items < 550) begin
      int n, mode;
      if ($urandom_range(0, 7) == 0) begin
        drain();
        write_reg(REG_LOOKAHEAD, 21'($urandom_range(1, 1048576)));
        write_reg(REG_WHEELBASE, 21'($urandom_range(1, 655360)));
        write_reg(REG_STEER_LIM, 21'($urandom_range(0, 12868)));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 14);
      mode = $urandom_range(0, 5) < 4 ? 2 : $urandom_range(0, 1);
      send_path(n, mode, $urandom_range(0, 3) != 0);
      items += n;
    end
    drain();
    write_reg(REG_LOOKAHEAD, LOOKAHEAD_RST);
    write_reg(REG_WHEELBASE, 21'(WHEELBASE_RST));
    write_reg(REG_STEER_LIM, 21'(STEER_LIM_RST));
    send_path(8, 2, 1);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** pure_pursuit_steering: PASSED **");
    end else begin
      $display("** pure_pursuit_steering: FAILED **");
    end
    $finish;
  end

endmodule
